### src/asmtok_pkg.sv
`default_nettype none

package asmtok_pkg;

	// Token kind codes
	localparam logic [3:0] KIND_HASH    = 4'd0;
	localparam logic [3:0] KIND_DOLLAR  = 4'd1;
	localparam logic [3:0] KIND_COLON   = 4'd2;
	localparam logic [3:0] KIND_PERCENT = 4'd3;
	localparam logic [3:0] KIND_BAR     = 4'd4;
	localparam logic [3:0] KIND_DOT     = 4'd5;
	localparam logic [3:0] KIND_IDENT   = 4'd6;
	localparam logic [3:0] KIND_INT     = 4'd7;
	localparam logic [3:0] KIND_END     = 4'd8;
	localparam logic [3:0] KIND_ILLEGAL = 4'd9;

	// One emitted token
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

endpackage

`default_nettype wire

### src/assembly_source_tokenizer_unit.sv
// An accepted character is registered, then its tokens are written to the queue.
// Throughput: one character per cycle while the queue has room; a character that
// yields two tokens writes both into the four-entry token queue.
// Input is taken while the queue has room for two tokens.
// Reset (arst_n low) returns to scanning at position zero and empties the queue.
`default_nettype none

module assembly_source_tokenizer_unit #(
	parameter int POSITION_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         char_valid,
	output logic        char_ready,
	input  wire  [7:0]  char_code,
	output logic        token_valid,
	input  wire         token_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	import asmtok_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       advance;
	logic [1:0] tok_count;
	token_t     tok0, tok1, head;

	assign advance    = valid_s1 && room;
	assign char_ready = !valid_s1 || room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready)
			char_s1 <= char_code;
	end

	asmtok_core #(.POSITION_BITS(POSITION_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.char_code (char_s1),
		.tok0      (tok0),
		.tok1      (tok1),
		.tok_count (tok_count)
	);

	asmtok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_count (advance ? tok_count : 2'd0),
		.wr_tok0  (tok0),
		.wr_tok1  (tok1),
		.room     (room),
		.rd_valid (token_valid),
		.rd_ready (token_ready),
		.rd_tok   (head)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule

`default_nettype wire

### src/asmtok_core.sv
`default_nettype none

module asmtok_core #(
	parameter int POSITION_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    advance,
	input  wire [7:0]              char_code,
	output asmtok_pkg::token_t     tok0,
	output asmtok_pkg::token_t     tok1,
	output logic [1:0]             tok_count
);
	import asmtok_pkg::*;

	// Scan mode codes
	localparam logic [2:0] MODE_SCAN    = 3'd0;
	localparam logic [2:0] MODE_IDENT   = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_COMMENT = 3'd3;
	localparam logic [2:0] MODE_DONE    = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DOLL  = 8'h24;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	logic [2:0]               mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] wstart_q;

	logic [2:0]               mode_d;
	logic                     wstart_set;
	logic                     is_alpha, is_digit, is_space;
	logic                     bt_valid;
	logic [3:0]               bt_kind;
	logic [15:0]              bt_len;
	logic [2:0]               bt_mode;
	logic                     bt_word;
	logic [POSITION_BITS-1:0] diff;
	logic [15:0]              pos16;
	logic [15:0]              word_len;
	logic [15:0]              wstart16;
	token_t                   word_tok;
	token_t                   bt_tok;

	// Character classes
	assign is_alpha = (char_code >= 8'h41 && char_code <= 8'h5A) ||
		(char_code >= 8'h61 && char_code <= 8'h7A) || (char_code == CH_USCORE);
	assign is_digit = (char_code >= 8'h30 && char_code <= 8'h39);
	assign is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);

	// Position and word length folded to 16-bit token fields
	assign diff = pos_q - wstart_q;
	generate
		if (POSITION_BITS > 16) begin : g_wide
			assign pos16    = pos_q[15:0];
			assign wstart16 = wstart_q[15:0];
			assign word_len = (|diff[POSITION_BITS-1:16]) ? 16'hFFFF : diff[15:0];
		end else begin : g_narrow
			assign pos16    = 16'(pos_q);
			assign wstart16 = 16'(wstart_q);
			assign word_len = 16'(diff);
		end
	endgenerate

	// Classify the byte as if between tokens
	always_comb begin
		bt_valid = 1'b1;
		bt_kind  = KIND_ILLEGAL;
		bt_len   = 16'd1;
		bt_mode  = MODE_SCAN;
		bt_word  = 1'b0;
		case (char_code)
			CH_HASH:  bt_kind = KIND_HASH;
			CH_DOLL:  bt_kind = KIND_DOLLAR;
			CH_COLON: bt_kind = KIND_COLON;
			CH_PCT:   bt_kind = KIND_PERCENT;
			CH_BAR:   bt_kind = KIND_BAR;
			CH_DOT:   bt_kind = KIND_DOT;
			CH_SEMI: begin
				bt_valid = 1'b0;
				bt_mode  = MODE_COMMENT;
			end
			CH_NUL: begin
				bt_kind = KIND_END;
				bt_len  = 16'd0;
				bt_mode = MODE_DONE;
			end
			default: begin
				if (is_space) begin
					bt_valid = 1'b0;
				end else if (is_alpha) begin
					bt_valid = 1'b0;
					bt_mode  = MODE_IDENT;
					bt_word  = 1'b1;
				end else if (is_digit) begin
					bt_valid = 1'b0;
					bt_mode  = MODE_NUMBER;
					bt_word  = 1'b1;
				end else begin
					bt_mode = MODE_DONE;
				end
			end
		endcase
	end

	assign bt_tok   = '{kind: bt_kind, start: pos16, length: bt_len, last: 1'b1};
	assign word_tok = '{kind: (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_INT,
		start: wstart16, length: word_len, last: !bt_valid};

	// Mode update and token selection
	always_comb begin
		mode_d     = mode_q;
		wstart_set = 1'b0;
		tok0       = bt_tok;
		tok1       = bt_tok;
		tok_count  = 2'd0;
		unique case (mode_q) inside
			MODE_SCAN: begin
				mode_d     = bt_mode;
				wstart_set = bt_word;
				tok_count  = {1'b0, bt_valid};
			end
			MODE_IDENT, MODE_NUMBER: begin
				if (is_digit || (is_alpha && mode_q == MODE_IDENT)) begin
					tok_count = 2'd0;
				end else begin
					mode_d     = bt_mode;
					wstart_set = bt_word;
					tok0       = word_tok;
					tok_count  = bt_valid ? 2'd2 : 2'd1;
				end
			end
			MODE_COMMENT: begin
				if (char_code == CH_NL) begin
					mode_d = MODE_SCAN;
				end else if (char_code == CH_NUL) begin
					mode_d    = bt_mode;
					tok_count = 2'd1;
				end
			end
			default: tok_count = 2'd0;
		endcase
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SCAN;
			pos_q    <= '0;
			wstart_q <= '0;
		end else if (advance && mode_q < MODE_DONE) begin
			mode_q <= mode_d;
			if (wstart_set)
				wstart_q <= pos_q;
			if (pos_q != {POSITION_BITS{1'b1}})
				pos_q <= pos_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### src/asmtok_fifo.sv
`default_nettype none

module asmtok_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire [1:0]           wr_count,
	input  asmtok_pkg::token_t  wr_tok0,
	input  asmtok_pkg::token_t  wr_tok1,
	output logic                room,
	output logic                rd_valid,
	input  wire                 rd_ready,
	output asmtok_pkg::token_t  rd_tok
);
	import asmtok_pkg::*;

	token_t     mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] count_q;
	logic       rd_fire;

	assign rd_valid = (count_q != 3'd0);
	assign rd_fire  = rd_valid && rd_ready;
	assign room     = (count_q <= 3'd2);
	assign rd_tok   = mem_q[rp_q];

	// Token storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (wr_count != 2'd0)
			mem_q[wp_q] <= wr_tok0;
		if (wr_count == 2'd2)
			mem_q[wp_q + 2'd1] <= wr_tok1;
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + wr_count;
			rp_q    <= rp_q + {1'b0, rd_fire};
			count_q <= count_q + {1'b0, wr_count} - {2'b00, rd_fire};
		end
	end

endmodule

`default_nettype wire
